// ===== hdl/dependency_graph_topo_sort_assert.svh =====
// Assertion macros for the checker file of the dependency graph sorter.
`ifndef DEPENDENCY_GRAPH_TOPO_SORT_ASSERT_SVH
`define DEPENDENCY_GRAPH_TOPO_SORT_ASSERT_SVH

// Same-cycle implication, sampled on clk and masked while rst_n is low.
`define DGTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dgts: same-cycle check failed");

// Next-cycle implication, sampled on clk and masked while rst_n is low.
`define DGTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dgts: next-cycle check failed");

`endif

// ===== hdl/dgts_pkg.sv =====
// Types and constants shared by the dependency graph sorter modules.
`default_nettype none

package dgts_pkg;

  // Default graph capacity.
  localparam int MAX_NODES_DEF = 32;

  // Fixed field widths of the transfer payloads.
  localparam int NODE_IDX_W   = 6;
  localparam int NODE_TOTAL_W = 7;
  localparam int EDGE_TOTAL_W = 13;

  // Operation codes.
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_CONNECT = 2'd1;
  localparam logic [1:0] OP_SORT    = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]            opcode;
    logic [NODE_IDX_W-1:0] from_node;
    logic [NODE_IDX_W-1:0] to_node;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [NODE_IDX_W-1:0]   node_index;
    logic                    node_valid;
    logic                    ok;
    logic                    has_cycle;
    logic                    last;
    logic [NODE_TOTAL_W-1:0] node_total;
    logic [EDGE_TOTAL_W-1:0] edge_total;
  } out_item_t;

  // Commands from the sequencer to the in-degree lanes.
  typedef struct packed {
    logic clear;  // zero all in-degrees and the emitted mask
    logic add;    // add one adjacency row into the in-degrees
    logic dec;    // remove the edges of one emitted node
    logic mark;   // mark the picked node as emitted
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/dgts_lanes.sv =====
// In-degree lanes, emitted mask and smallest-index ready pick of the sorter.
`default_nettype none

module dgts_lanes #(
  parameter int MAX_NODES = dgts_pkg::MAX_NODES_DEF,
  localparam int AW = $clog2(MAX_NODES),
  localparam int DW = $clog2(MAX_NODES + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dgts_pkg::lane_ctl_t   ctl,
  input  wire logic [MAX_NODES-1:0]  row,
  input  wire logic [MAX_NODES-1:0]  node_mask,
  output logic                       any_ready,
  output logic [AW-1:0]              pick_idx
);

  logic [DW-1:0]        indeg_r [MAX_NODES];
  logic [MAX_NODES-1:0] emitted_r;
  logic [MAX_NODES-1:0] ready;
  logic [MAX_NODES-1:0] lowest;

  // Each lane counts the edges into its node from nodes not yet emitted.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_NODES; j++) begin
      if (ctl.clear) begin
        indeg_r[j] <= '0;
      end else if (ctl.add) begin
        indeg_r[j] <= indeg_r[j] + DW'(row[j]);
      end else if (ctl.dec && row[j] && (indeg_r[j] != '0)) begin
        indeg_r[j] <= indeg_r[j] - DW'(1);
      end
    end
  end

  // Nodes already placed in the order.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emitted_r <= '0;
    end else if (ctl.clear) begin
      emitted_r <= '0;
    end else if (ctl.mark) begin
      emitted_r[pick_idx] <= 1'b1;
    end
  end

  // A node is ready when it exists, is not emitted and has no open in-edge.
  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      ready[j] = node_mask[j] && !emitted_r[j] && (indeg_r[j] == '0);
    end
  end

  // Isolate the lowest ready node and encode its index.
  assign lowest    = ready & (~ready + MAX_NODES'(1));
  assign any_ready = |ready;

  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < MAX_NODES; j++) begin
      if (lowest[j]) begin
        pick_idx = pick_idx | AW'(j);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dependency_graph_topo_sort.sv =====
// Top level of the dependency graph sorter: graph store and sequencer.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready   | dgts_pkg::in_item_t
//   out_    | output    | out_valid / out_ready | dgts_pkg::out_item_t
//
// Add node answers through the result state; a valid connect reads the source row, sets
// the edge bit if it is new and then answers. Sort counts in-degrees with one adjacency
// memory read per cycle, then reads one row per ordered node to retire its out-edges;
// the single memory read port sets this pace. Reset (synchronous, rst_n low) empties the
// graph; rows are cleared as nodes are added, so no clearing pass runs. A stalled result
// holds the sequencer.
`default_nettype none

module dependency_graph_topo_sort #(
  parameter int MAX_NODES = dgts_pkg::MAX_NODES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dgts_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output dgts_pkg::out_item_t      out_item
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int NW = dgts_pkg::NODE_IDX_W;
  localparam int CW = dgts_pkg::NODE_TOTAL_W;
  localparam int EW = dgts_pkg::EDGE_TOTAL_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RESP,
    S_CONN_RD,
    S_CONN_WR,
    S_CLR,
    S_COUNT,
    S_PICK,
    S_DEC
  } state_t;

  state_t              state_r;
  logic [CW-1:0]       node_cnt_r;
  logic [EW-1:0]       edge_cnt_r;
  logic [AW-1:0]       from_r;
  logic [AW-1:0]       to_r;
  logic [CW-1:0]       issue_r;
  logic                rd_vld_r;
  logic [AW-1:0]       pend_r;
  logic                have_pend_r;
  logic [CW-1:0]       emit_cnt_r;
  logic [NW-1:0]       res_idx_r;
  logic                res_valid_r;
  logic                res_ok_r;
  dgts_pkg::out_item_t out_r;
  logic                out_valid_r;

  logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0] rd_data_r;
  logic [AW-1:0]        mem_raddr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [MAX_NODES-1:0] mem_wdata;
  logic [MAX_NODES-1:0] to_bit;
  logic [MAX_NODES-1:0] node_mask;

  dgts_pkg::lane_ctl_t lane_ctl;
  logic                any_ready;
  logic [AW-1:0]       pick_idx;

  logic in_fire;
  logic slot_free;
  logic out_load;
  logic full;
  logic conn_bad;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // A new result enters the output register when the slot is free.
  assign out_load = slot_free &&
                    ((state_r == S_RESP) ||
                     ((state_r == S_PICK) && (!any_ready || have_pend_r)));

  assign full     = (node_cnt_r >= CW'(MAX_NODES));
  assign conn_bad = ({1'b0, in_item.from_node} >= node_cnt_r) ||
                    ({1'b0, in_item.to_node} >= node_cnt_r);

  // Column masks for existing nodes and for the edge target.
  always_comb begin
    to_bit = '0;
    to_bit[to_r] = 1'b1;
    for (int j = 0; j < MAX_NODES; j++) begin
      node_mask[j] = (node_cnt_r > CW'(j));
    end
  end

  // Memory read address by phase of the sequencer.
  always_comb begin
    unique case (state_r)
      S_CONN_RD: mem_raddr = from_r;
      S_COUNT:   mem_raddr = issue_r[AW-1:0];
      S_PICK:    mem_raddr = pick_idx;
      default:   mem_raddr = '0;
    endcase
  end

  // Memory writes: a new node clears its row, a new edge sets one bit.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = from_r;
    mem_wdata = rd_data_r | to_bit;
    if (in_fire && (in_item.opcode == dgts_pkg::OP_ADD) && !full) begin
      mem_we    = 1'b1;
      mem_waddr = node_cnt_r[AW-1:0];
      mem_wdata = '0;
    end else if ((state_r == S_CONN_WR) && !rd_data_r[to_r]) begin
      mem_we = 1'b1;
    end
  end

  // Adjacency matrix, one row per node.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      adj_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= adj_mem[mem_raddr];
  end

  // Lane commands.
  always_comb begin
    lane_ctl.clear = (state_r == S_CLR);
    lane_ctl.add   = (state_r == S_COUNT) && rd_vld_r;
    lane_ctl.dec   = (state_r == S_DEC);
    lane_ctl.mark  = (state_r == S_PICK) && any_ready && (!have_pend_r || slot_free);
  end

  dgts_lanes #(
    .MAX_NODES (MAX_NODES)
  ) u_lanes (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (lane_ctl),
    .row       (rd_data_r),
    .node_mask (node_mask),
    .any_ready (any_ready),
    .pick_idx  (pick_idx)
  );

  // Sequencer with counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      node_cnt_r  <= '0;
      edge_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      have_pend_r <= 1'b0;
      issue_r     <= '0;
      emit_cnt_r  <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_idx_r   <= '0;
            res_valid_r <= 1'b0;
            res_ok_r    <= 1'b0;
            from_r      <= in_item.from_node[AW-1:0];
            to_r        <= in_item.to_node[AW-1:0];
            unique case (in_item.opcode)
              dgts_pkg::OP_ADD: begin
                if (!full) begin
                  res_idx_r   <= node_cnt_r[NW-1:0];
                  res_valid_r <= 1'b1;
                  res_ok_r    <= 1'b1;
                  node_cnt_r  <= node_cnt_r + CW'(1);
                end
                state_r <= S_RESP;
              end
              dgts_pkg::OP_CONNECT: begin
                state_r <= conn_bad ? S_RESP : S_CONN_RD;
              end
              dgts_pkg::OP_SORT: begin
                state_r <= S_CLR;
              end
              default: begin
                state_r <= S_RESP;
              end
            endcase
          end
        end
        S_RESP: begin
          if (slot_free) begin
            out_r.node_index <= res_idx_r;
            out_r.node_valid <= res_valid_r;
            out_r.ok         <= res_ok_r;
            out_r.has_cycle  <= 1'b0;
            out_r.last       <= 1'b1;
            out_r.node_total <= node_cnt_r;
            out_r.edge_total <= edge_cnt_r;
            state_r          <= S_IDLE;
          end
        end
        S_CONN_RD: begin
          state_r <= S_CONN_WR;
        end
        S_CONN_WR: begin
          // A duplicate edge leaves the count alone.
          if (!rd_data_r[to_r]) begin
            edge_cnt_r <= edge_cnt_r + EW'(1);
          end
          res_ok_r <= 1'b1;
          state_r  <= S_RESP;
        end
        S_CLR: begin
          issue_r     <= '0;
          rd_vld_r    <= 1'b0;
          have_pend_r <= 1'b0;
          emit_cnt_r  <= '0;
          state_r     <= (node_cnt_r == '0) ? S_PICK : S_COUNT;
        end
        S_COUNT: begin
          // One row read per cycle; the lanes add it in the next cycle.
          if (issue_r < node_cnt_r) begin
            issue_r  <= issue_r + CW'(1);
            rd_vld_r <= 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if ((issue_r == node_cnt_r) && rd_vld_r) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (any_ready) begin
            // The held node is not the last one: send it on.
            if (!have_pend_r || slot_free) begin
              if (have_pend_r) begin
                out_r.node_index <= NW'(pend_r);
                out_r.node_valid <= 1'b1;
                out_r.ok         <= 1'b1;
                out_r.has_cycle  <= 1'b0;
                out_r.last       <= 1'b0;
                out_r.node_total <= node_cnt_r;
                out_r.edge_total <= edge_cnt_r;
              end
              pend_r      <= pick_idx;
              have_pend_r <= 1'b1;
              emit_cnt_r  <= emit_cnt_r + CW'(1);
              state_r     <= S_DEC;
            end
          end else if (slot_free) begin
            // Nothing more is ready: close the order.
            out_r.node_index <= have_pend_r ? NW'(pend_r) : '0;
            out_r.node_valid <= have_pend_r;
            out_r.ok         <= 1'b1;
            out_r.has_cycle  <= (emit_cnt_r != node_cnt_r);
            out_r.last       <= 1'b1;
            out_r.node_total <= node_cnt_r;
            out_r.edge_total <= edge_cnt_r;
            state_r          <= S_IDLE;
          end
        end
        S_DEC: begin
          state_r <= S_PICK;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/dgts_checker.sv =====
// Port-level checker for the dependency graph sorter and its bind.
`default_nettype none

`include "dependency_graph_topo_sort_assert.svh"

module dgts_checker #(
  parameter int MAX_NODES = dgts_pkg::MAX_NODES_DEF
) (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire dgts_pkg::out_item_t out_item
);

  // A result waiting for its transfer keeps its contents.
  `DGTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item))

  // Every item keeps the block busy: in_ready is low after each accepted item.
  `DGTS_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready)

  // A result that names a node always reports success.
  `DGTS_ASSERT_IMPL(a_node_ok, out_valid && out_item.node_valid, out_item.ok)

  // A cycle is reported only on the closing result of a sort.
  `DGTS_ASSERT_IMPL(a_cycle_last, out_valid && out_item.has_cycle, out_item.last && out_item.ok)

  // The node count never exceeds the capacity.
  `DGTS_ASSERT_IMPL(a_node_bound, out_valid, out_item.node_total <= 7'(MAX_NODES))

endmodule

bind dependency_graph_topo_sort dgts_checker #(
  .MAX_NODES (MAX_NODES)
) u_dgts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

`default_nettype wire

// ===== test/tb_dependency_graph_topo_sort.sv =====
// Self-checking testbench for the dependency graph sorter with its own graph predictor.
`timescale 1ns / 1ps

module tb_dependency_graph_topo_sort;

  localparam int MAX_NODES = dgts_pkg::MAX_NODES_DEF;
  localparam int NW = dgts_pkg::NODE_IDX_W;
  localparam int CW = dgts_pkg::NODE_TOTAL_W;
  localparam int EW = dgts_pkg::EDGE_TOTAL_W;
  // The unused opcode, which the block answers with a single failed result.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Nodes below this index are in or behind cycles made by the directed part.
  localparam int FRESH_BASE = 5;
  localparam int RANDOM_ITEMS = 389;
  localparam int DRAIN_CYCLES = 160;
  localparam int MAX_REPORTS = 50;
  localparam int DIRECTED_ROWS = 21;

  typedef struct {
    dgts_pkg::in_item_t  item;
    bit                  typed;
    dgts_pkg::out_item_t want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  dgts_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dgts_pkg::out_item_t out_item;

  // Predicted graph state.
  logic [MAX_NODES-1:0] adj_rows [MAX_NODES];
  int node_cnt = 0;
  int edge_cnt = 0;

  dgts_pkg::out_item_t op_results [$];
  dgts_pkg::out_item_t pending_results [$];
  int mismatch_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  dir_row_t dir_rows [DIRECTED_ROWS];

  dependency_graph_topo_sort #(.MAX_NODES(MAX_NODES)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Receiver stalls at random at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  function automatic dgts_pkg::out_item_t want_res(int idx, bit valid, bit ok, bit cyc,
                                                   bit fin, int nodes, int edges);
    dgts_pkg::out_item_t r;
    r.node_index = NW'(idx);
    r.node_valid = valid;
    r.ok = ok;
    r.has_cycle = cyc;
    r.last = fin;
    r.node_total = CW'(nodes);
    r.edge_total = EW'(edges);
    return r;
  endfunction

  function automatic dir_row_t dir_row(logic [1:0] op, int from, int to, bit typed,
                                       dgts_pkg::out_item_t want);
    dir_row_t d;
    d.item.opcode = op;
    d.item.from_node = NW'(from);
    d.item.to_node = NW'(to);
    d.typed = typed;
    d.want = want;
    return d;
  endfunction

  // Applies one operation to the predicted graph and leaves its results in op_results.
  task automatic apply_graph_op(input dgts_pkg::in_item_t it);
    int indeg [MAX_NODES];
    logic [MAX_NODES-1:0] ready;
    int order [$];
    int v;
    bit cyc;
    op_results.delete();
    case (it.opcode)
      dgts_pkg::OP_ADD: begin
        if (node_cnt >= MAX_NODES) begin
          op_results.push_back(want_res(0, 0, 0, 0, 1, node_cnt, edge_cnt));
        end else begin
          adj_rows[node_cnt] = '0;
          node_cnt++;
          op_results.push_back(want_res(node_cnt - 1, 1, 1, 0, 1, node_cnt, edge_cnt));
        end
      end
      dgts_pkg::OP_CONNECT: begin
        if (it.from_node >= node_cnt || it.to_node >= node_cnt) begin
          op_results.push_back(want_res(0, 0, 0, 0, 1, node_cnt, edge_cnt));
        end else begin
          // A duplicate edge leaves the count alone.
          if (!adj_rows[it.from_node][it.to_node]) begin
            adj_rows[it.from_node][it.to_node] = 1'b1;
            edge_cnt++;
          end
          op_results.push_back(want_res(0, 0, 1, 0, 1, node_cnt, edge_cnt));
        end
      end
      dgts_pkg::OP_SORT: begin
        // Count in-degrees, then repeatedly retire the lowest ready node.
        for (int j = 0; j < MAX_NODES; j++) indeg[j] = 0;
        for (int i = 0; i < node_cnt; i++) begin
          for (int j = 0; j < node_cnt; j++) begin
            if (adj_rows[i][j]) indeg[j]++;
          end
        end
        ready = '0;
        for (int j = 0; j < node_cnt; j++) begin
          if (indeg[j] == 0) ready[j] = 1'b1;
        end
        while (ready != '0) begin
          v = 0;
          while (!ready[v]) v++;
          ready[v] = 1'b0;
          order.push_back(v);
          for (int j = 0; j < node_cnt; j++) begin
            if (adj_rows[v][j] && indeg[j] != 0) begin
              indeg[j]--;
              if (indeg[j] == 0) ready[j] = 1'b1;
            end
          end
        end
        cyc = (order.size() != node_cnt);
        if (order.size() == 0) begin
          op_results.push_back(want_res(0, 0, 1, cyc, 1, node_cnt, edge_cnt));
        end else begin
          for (int n = 0; n < order.size(); n++) begin
            if (n + 1 == order.size()) begin
              op_results.push_back(want_res(order[n], 1, 1, cyc, 1, node_cnt, edge_cnt));
            end else begin
              op_results.push_back(want_res(order[n], 1, 1, 0, 0, node_cnt, edge_cnt));
            end
          end
        end
      end
      default: begin
        op_results.push_back(want_res(0, 0, 0, 0, 1, node_cnt, edge_cnt));
      end
    endcase
  endtask

  // Drives one item, waits for its transfer, and records what it should produce.
  task automatic send_item(input dgts_pkg::in_item_t it, input bit typed,
                           input dgts_pkg::out_item_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    apply_graph_op(it);
    if (typed) begin
      pending_results.push_back(want);
    end else begin
      foreach (op_results[k]) pending_results.push_back(op_results[k]);
    end
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Mostly acyclic edges among the fresh nodes, with adds, sorts and some noise.
  function automatic dgts_pkg::in_item_t pick_random_op(bit allow_back);
    dgts_pkg::in_item_t it;
    int roll;
    int a;
    int b;
    int t;
    roll = $urandom_range(99);
    it.opcode = dgts_pkg::OP_SORT;
    it.from_node = NW'($urandom_range(63));
    it.to_node = NW'($urandom_range(63));
    if ((node_cnt < MAX_NODES && roll < 20) || roll < 3) begin
      it.opcode = dgts_pkg::OP_ADD;
    end else if (roll < 34) begin
      it.opcode = dgts_pkg::OP_SORT;
    end else if (roll < 40) begin
      // Random indices: mostly unknown nodes.
      it.opcode = dgts_pkg::OP_CONNECT;
    end else if (roll < 42) begin
      it.opcode = OP_UNUSED;
    end else if (node_cnt - FRESH_BASE < 2) begin
      it.opcode = dgts_pkg::OP_ADD;
    end else begin
      a = $urandom_range(node_cnt - 2, FRESH_BASE);
      b = $urandom_range(node_cnt - 1, a + 1);
      if (allow_back && $urandom_range(14) == 0) begin
        t = a;
        a = b;
        b = t;
      end else if (allow_back && $urandom_range(39) == 0) begin
        b = a;
      end
      it.opcode = dgts_pkg::OP_CONNECT;
      it.from_node = NW'(a);
      it.to_node = NW'(b);
    end
    return it;
  endfunction

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk) begin : check_results
    dgts_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transfer with nothing expected, node_index",
                        int'(out_item.node_index), 0);
      end else begin
        want = pending_results.pop_front();
        if (out_item.node_index !== want.node_index)
          report_mismatch("node_index", int'(out_item.node_index), int'(want.node_index));
        if (out_item.node_valid !== want.node_valid)
          report_mismatch("node_valid", int'(out_item.node_valid), int'(want.node_valid));
        if (out_item.ok !== want.ok)
          report_mismatch("ok", int'(out_item.ok), int'(want.ok));
        if (out_item.has_cycle !== want.has_cycle)
          report_mismatch("has_cycle", int'(out_item.has_cycle), int'(want.has_cycle));
        if (out_item.last !== want.last)
          report_mismatch("last", int'(out_item.last), int'(want.last));
        if (out_item.node_total !== want.node_total)
          report_mismatch("node_total", int'(out_item.node_total), int'(want.node_total));
        if (out_item.edge_total !== want.edge_total)
          report_mismatch("edge_total", int'(out_item.edge_total), int'(want.edge_total));
      end
    end
  end

  // Stimulus: reset, directed table, then three random phases with different idling.
  initial begin
    dgts_pkg::out_item_t none;
    none = '0;
    // Directed rows; typed expectations where the answer is obvious.
    dir_rows[0]  = dir_row(dgts_pkg::OP_SORT, 0, 0, 1, want_res(0, 0, 1, 0, 1, 0, 0));
    dir_rows[1]  = dir_row(dgts_pkg::OP_CONNECT, 0, 0, 1, want_res(0, 0, 0, 0, 1, 0, 0));
    dir_rows[2]  = dir_row(OP_UNUSED, 63, 63, 1, want_res(0, 0, 0, 0, 1, 0, 0));
    dir_rows[3]  = dir_row(dgts_pkg::OP_ADD, 0, 0, 1, want_res(0, 1, 1, 0, 1, 1, 0));
    dir_rows[4]  = dir_row(dgts_pkg::OP_ADD, 63, 63, 1, want_res(1, 1, 1, 0, 1, 2, 0));
    dir_rows[5]  = dir_row(dgts_pkg::OP_ADD, 0, 0, 1, want_res(2, 1, 1, 0, 1, 3, 0));
    dir_rows[6]  = dir_row(dgts_pkg::OP_CONNECT, 0, 1, 1, want_res(0, 0, 1, 0, 1, 3, 1));
    dir_rows[7]  = dir_row(dgts_pkg::OP_CONNECT, 0, 1, 1, want_res(0, 0, 1, 0, 1, 3, 1));
    dir_rows[8]  = dir_row(dgts_pkg::OP_CONNECT, 1, 2, 1, want_res(0, 0, 1, 0, 1, 3, 2));
    dir_rows[9]  = dir_row(dgts_pkg::OP_CONNECT, 63, 0, 1, want_res(0, 0, 0, 0, 1, 3, 2));
    dir_rows[10] = dir_row(dgts_pkg::OP_CONNECT, 0, 63, 1, want_res(0, 0, 0, 0, 1, 3, 2));
    dir_rows[11] = dir_row(dgts_pkg::OP_CONNECT, 3, 0, 1, want_res(0, 0, 0, 0, 1, 3, 2));
    dir_rows[12] = dir_row(dgts_pkg::OP_SORT, 0, 0, 0, none);
    dir_rows[13] = dir_row(dgts_pkg::OP_ADD, 0, 0, 1, want_res(3, 1, 1, 0, 1, 4, 2));
    dir_rows[14] = dir_row(dgts_pkg::OP_ADD, 0, 0, 1, want_res(4, 1, 1, 0, 1, 5, 2));
    dir_rows[15] = dir_row(dgts_pkg::OP_CONNECT, 4, 3, 1, want_res(0, 0, 1, 0, 1, 5, 3));
    dir_rows[16] = dir_row(dgts_pkg::OP_SORT, 42, 21, 0, none);
    dir_rows[17] = dir_row(dgts_pkg::OP_CONNECT, 2, 0, 1, want_res(0, 0, 1, 0, 1, 5, 4));
    dir_rows[18] = dir_row(dgts_pkg::OP_SORT, 0, 0, 0, none);
    dir_rows[19] = dir_row(dgts_pkg::OP_CONNECT, 4, 4, 1, want_res(0, 0, 1, 0, 1, 5, 5));
    dir_rows[20] = dir_row(dgts_pkg::OP_SORT, 21, 42, 0, none);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, sender steady, receiver mostly stalling.
    send_gap_pct = 7;
    recv_stall_pct = 75;
    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

    // Random part in three idling phases, draining between them.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        wait_drained();
        send_gap_pct = 75;
        recv_stall_pct = 7;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        wait_drained();
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      send_item(pick_random_op(n >= 4 * RANDOM_ITEMS / 5), 0, none);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("tb_dependency_graph_topo_sort passed");
    end else begin
      $display("tb_dependency_graph_topo_sort failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(10_000_000);
    $display("tb_dependency_graph_topo_sort failed");
    $finish;
  end

endmodule
